// ----- hw/rtl/audio_jitter_buffer_controller_assert.svh -----
// Assertion macros for the jitter buffer controller checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef AUDIO_JITTER_BUFFER_CONTROLLER_ASSERT_SVH
`define AUDIO_JITTER_BUFFER_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define AJBC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AJBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ajbc_pkg.sv -----
// Shared types, codes and constants of the jitter buffer controller.
// No dependencies.
`timescale 1ns / 1ps

package ajbc_pkg;

    typedef logic [63:0] seq_t;

    typedef struct packed {
        logic        cmd;
        logic        addr_match;
        logic [15:0] src_port;
        logic [11:0] length;
        logic        ping_match;
        logic [7:0]  hdr_byte0;
        logic [7:0]  hdr_byte1;
        logic [15:0] seq_number;
        logic [31:0] magic_word;
        logic        payload_ok;
    } in_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  store_slot;
        logic        store_valid;
        logic        reset_decoder;
        logic [1:0]  play_action;
        logic [1:0]  play_slot;
        logic [15:0] play_seq;
    } out_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } ctrl_sts_t;

    localparam logic CMD_DATAGRAM = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic [1:0] PLAY_NONE    = 2'd0;
    localparam logic [1:0] PLAY_DECODE  = 2'd1;
    localparam logic [1:0] PLAY_CONCEAL = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONCEAL_LIMIT = 3'd4;

    localparam logic [11:0] MAX_LEN_RST       = 12'd1400;
    localparam logic [7:0]  JUMP_LIMIT_RST    = 8'd8;
    localparam logic [2:0]  STARTUP_COUNT_RST = 3'd2;
    localparam logic [2:0]  CONCEAL_LIMIT_RST = 3'd2;

    localparam logic [11:0] PING_LEN    = 12'd20;
    localparam logic [11:0] MIN_HDR_LEN = 12'd12;
    localparam logic [7:0]  HDR0_VAL    = 8'h00;
    localparam logic [7:0]  HDR1_VAL    = 8'h61;
    localparam logic [31:0] MAGIC_VAL   = 32'h12345678;
    localparam logic [2:0]  MISSING_MAX = 3'd7;

    function automatic logic seq_lt(input seq_t a, input seq_t b);
        seq_t d;
        d = a - b;
        return d[63];
    endfunction

endpackage

// ----- hw/rtl/audio_jitter_buffer_controller.sv -----
// Jitter buffer controller for one audio stream. A beat is taken when start is high
// and busy low; its result strobes on done for one cycle, registered after load, extend, scan, commit.
// The sequence table is scanned one entry a cycle; no new beat is taken until the last is done.
// Busy drops in the strobe cycle, so the next beat may start then; done cannot be stalled.
// Reset clears control and stream state, loads config defaults and empties the table.
// Depends on ajbc_pkg, ajbc_ctrl and ajbc_datapath.
`timescale 1ns / 1ps

module audio_jitter_buffer_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ajbc_pkg::in_t                   item,
    output logic                            done,
    output ajbc_pkg::out_t                  result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ajbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ajbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ajbc_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    assign cfg_ready = 1'b1;

    ajbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (ctrl_cmd),
        .sts   (ctrl_sts)
    );

    ajbc_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .sts       (ctrl_sts),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

// ----- hw/rtl/ajbc_ctrl.sv -----
// Sequencer of the jitter buffer controller: load, extend, table scan, commit.
// Depends on ajbc_pkg.
`timescale 1ns / 1ps

module ajbc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output ajbc_pkg::ctrl_cmd_t cmd,
    input  ajbc_pkg::ctrl_sts_t sts
);
    import ajbc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/ajbc_datapath.sv -----
// Datapath of the jitter buffer controller: config registers, stream state,
// sequence table with its scan accumulators, and the result register. Depends on ajbc_pkg.
`timescale 1ns / 1ps

module ajbc_datapath #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ajbc_pkg::ctrl_cmd_t                cmd,
    output ajbc_pkg::ctrl_sts_t                sts,
    input  ajbc_pkg::in_t                      item,
    input  logic                               cfg_we,
    input  logic [ajbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ajbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ajbc_pkg::out_t                     result,
    output logic                               done
);
    import ajbc_pkg::*;

    localparam int IDXW = $clog2(QUEUE_DEPTH);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(QUEUE_DEPTH - 1);

    logic             enable_reg;
    logic [11:0]      max_len_reg;
    logic [7:0]       jump_limit_reg;
    logic [2:0]       startup_count_reg;
    logic [2:0]       conceal_limit_reg;

    logic             peer_bound_reg, peer_bound_next;
    logic [15:0]      remote_port_reg, remote_port_next;
    logic             have_last_reg, have_last_next;
    logic [15:0]      last_seq_reg, last_seq_next;
    seq_t             highest_reg, highest_next;
    seq_t             play_reg, play_next;
    logic [2:0]       startup_reg, startup_next;
    logic [2:0]       missing_reg, missing_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    seq_t             entry_reg [QUEUE_DEPTH];

    in_t              item_reg;
    seq_t             ext_reg;
    seq_t             playj_reg;
    logic             dist_pos_reg;

    logic [IDXW-1:0]  idx_reg;
    logic             match_found_reg;
    logic [IDXW-1:0]  match_idx_reg;
    logic             free_found_reg;
    logic [IDXW-1:0]  free_idx_reg;
    logic             nonempty_reg;
    seq_t             far_seq_reg;
    logic [IDXW-1:0]  far_idx_reg;

    out_t             res_reg, res_next;
    logic             done_reg;

    logic [15:0]      raw;
    seq_t             target;
    seq_t             cur_entry;
    logic             cur_valid;
    logic             rej_early;
    logic             is_ping;
    logic             hdr_bad;
    logic             jump;
    logic             store_ok;
    logic [IDXW-1:0]  slot_sel;
    logic             wr_en;

    assign raw       = have_last_reg ? (item_reg.seq_number - last_seq_reg) : 16'd0;
    assign target    = (item_reg.cmd == CMD_TICK) ? play_reg : ext_reg;
    assign cur_entry = entry_reg[idx_reg];
    assign cur_valid = valid_reg[idx_reg];
    assign sts.scan_last = (idx_reg == LAST_IDX);

    assign rej_early = !enable_reg || !item_reg.addr_match || (item_reg.src_port == 16'd0);
    assign is_ping   = (item_reg.length == PING_LEN) && item_reg.ping_match;
    assign hdr_bad   = !peer_bound_reg || (remote_port_reg != item_reg.src_port)
                       || (item_reg.length <= MIN_HDR_LEN) || (item_reg.length > max_len_reg)
                       || (item_reg.hdr_byte0 != HDR0_VAL) || (item_reg.hdr_byte1 != HDR1_VAL)
                       || (item_reg.magic_word != MAGIC_VAL);
    assign jump      = have_last_reg && seq_lt(playj_reg, ext_reg);

    always_comb
    begin
        store_ok = 1'b1;
        slot_sel = far_idx_reg;
        if (jump)
        begin
            slot_sel = '0;
        end
        else if (free_found_reg)
        begin
            slot_sel = free_idx_reg;
        end
        else if (seq_lt(far_seq_reg, ext_reg))
        begin
            store_ok = 1'b0;
        end
    end

    always_comb
    begin
        peer_bound_next  = peer_bound_reg;
        remote_port_next = remote_port_reg;
        have_last_next   = have_last_reg;
        last_seq_next    = last_seq_reg;
        highest_next     = highest_reg;
        play_next        = play_reg;
        startup_next     = startup_reg;
        missing_next     = missing_reg;
        valid_next       = valid_reg;
        res_next         = '0;
        wr_en            = 1'b0;
        if (cmd.commit)
        begin
            if (item_reg.cmd == CMD_TICK)
            begin
                if (enable_reg && have_last_reg)
                begin
                    if (startup_reg != 3'd0)
                    begin
                        startup_next = startup_reg - 3'd1;
                    end
                    else if (!match_found_reg)
                    begin
                        if (missing_reg < conceal_limit_reg)
                        begin
                            res_next.play_action = PLAY_CONCEAL;
                        end
                        if (missing_reg != MISSING_MAX)
                        begin
                            missing_next = missing_reg + 3'd1;
                        end
                        if (nonempty_reg)
                        begin
                            play_next = play_reg + 64'd1;
                        end
                    end
                    else
                    begin
                        play_next                = play_reg + 64'd1;
                        missing_next             = 3'd0;
                        valid_next[match_idx_reg] = 1'b0;
                        res_next.play_action     = PLAY_DECODE;
                        res_next.play_slot       = 2'(match_idx_reg);
                        res_next.play_seq        = play_reg[15:0];
                    end
                end
            end
            else if (rej_early)
            begin
                res_next = '0;
            end
            else if (is_ping)
            begin
                if (!peer_bound_reg)
                begin
                    peer_bound_next  = 1'b1;
                    remote_port_next = item_reg.src_port;
                end
                res_next.accepted = !peer_bound_reg || (remote_port_reg == item_reg.src_port);
            end
            else if (hdr_bad || (have_last_reg && (seq_lt(ext_reg, play_reg) || match_found_reg))
                     || !item_reg.payload_ok)
            begin
                res_next = '0;
            end
            else
            begin
                if (!have_last_reg || jump)
                begin
                    play_next    = ext_reg;
                    startup_next = startup_count_reg;
                end
                if (jump)
                begin
                    valid_next             = '0;
                    res_next.reset_decoder = 1'b1;
                end
                if (!have_last_reg || dist_pos_reg)
                begin
                    have_last_next = 1'b1;
                    last_seq_next  = item_reg.seq_number;
                    highest_next   = ext_reg;
                end
                if (store_ok)
                begin
                    valid_next[slot_sel] = 1'b1;
                    wr_en                = 1'b1;
                    res_next.accepted    = 1'b1;
                    res_next.store_slot  = 2'(slot_sel);
                    res_next.store_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            max_len_reg       <= MAX_LEN_RST;
            jump_limit_reg    <= JUMP_LIMIT_RST;
            startup_count_reg <= STARTUP_COUNT_RST;
            conceal_limit_reg <= CONCEAL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:        enable_reg        <= cfg_data[0];
                CFG_MAX_LEN:       max_len_reg       <= cfg_data;
                CFG_JUMP_LIMIT:    jump_limit_reg    <= cfg_data[7:0];
                CFG_STARTUP_COUNT: startup_count_reg <= cfg_data[2:0];
                CFG_CONCEAL_LIMIT: conceal_limit_reg <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_bound_reg  <= 1'b0;
            remote_port_reg <= 16'd0;
            have_last_reg   <= 1'b0;
            last_seq_reg    <= 16'd0;
            highest_reg     <= '0;
            play_reg        <= '0;
            startup_reg     <= 3'd0;
            missing_reg     <= 3'd0;
            valid_reg       <= '0;
            done_reg        <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            peer_bound_reg  <= peer_bound_next;
            remote_port_reg <= remote_port_next;
            have_last_reg   <= have_last_next;
            last_seq_reg    <= last_seq_next;
            highest_reg     <= highest_next;
            play_reg        <= play_next;
            startup_reg     <= startup_next;
            missing_reg     <= missing_next;
            valid_reg       <= valid_next;
            done_reg        <= cmd.commit;
            if (cmd.calc)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan && !sts.scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.calc)
        begin
            ext_reg         <= highest_reg + {{48{raw[15]}}, raw};
            playj_reg       <= play_reg + {56'd0, jump_limit_reg};
            dist_pos_reg    <= (raw != 16'd0) && !raw[15];
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            nonempty_reg    <= 1'b0;
            far_idx_reg     <= '0;
        end
        else if (cmd.scan)
        begin
            if (cur_valid && (cur_entry == target) && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= idx_reg;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (cur_valid)
            begin
                nonempty_reg <= 1'b1;
            end
            if (idx_reg == '0)
            begin
                far_seq_reg <= cur_entry;
                far_idx_reg <= '0;
            end
            else if (cur_valid && seq_lt(far_seq_reg, cur_entry))
            begin
                far_seq_reg <= cur_entry;
                far_idx_reg <= idx_reg;
            end
        end
        if (wr_en)
        begin
            entry_reg[slot_sel] <= ext_reg;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// ----- hw/rtl/ajbc_checker.sv -----
// Port-level checks of the jitter buffer controller, bound to the top level.
// Depends on ajbc_pkg and audio_jitter_buffer_controller_assert.svh.
`timescale 1ns / 1ps

`include "audio_jitter_buffer_controller_assert.svh"

module ajbc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input ajbc_pkg::out_t result
);
    import ajbc_pkg::*;

    `AJBC_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
    `AJBC_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "beat taken without busy")
    `AJBC_ASSERT_IMPL(a_tick_fields, done && (result.play_action != PLAY_NONE), !result.accepted && !result.store_valid && !result.reset_decoder, "datagram fields set on a tick result")
    `AJBC_ASSERT_IMPL(a_slot_zero, done && !result.store_valid, result.store_slot == 2'd0, "store slot set without store")

endmodule

bind audio_jitter_buffer_controller ajbc_checker u_ajbc_checker (.*);

// ----- tb/sv/audio_jitter_buffer_controller_tb.sv -----
// Self-checking testbench for the audio jitter buffer controller: drives datagram and tick
// beats, programs the five control registers and predicts every result in a scoreboard.
// Depends on ajbc_pkg and audio_jitter_buffer_controller.
`timescale 1ns / 1ps

module audio_jitter_buffer_controller_tb;

    import ajbc_pkg::*;

    localparam int TABLE_DEPTH = 4;
    localparam int LATENCY     = TABLE_DEPTH + 3;

    class jitter_tracker;
        bit          en;
        logic [11:0] max_len;
        logic [7:0]  jump_lim;
        logic [2:0]  startup_cnt;
        logic [2:0]  conceal_lim;

        bit          bound;
        logic [15:0] bound_port;
        bit          have_last;
        logic [15:0] last_seq;
        seq_t        top_seq;
        seq_t        play_pos;
        logic [2:0]  startup_left;
        logic [2:0]  missing_run;
        bit          slot_used[TABLE_DEPTH];
        seq_t        slot_seq[TABLE_DEPTH];

        out_t        expected_results[$];
        int          errors;
        int          n_items;
        int          n_stored;
        int          n_decoded;
        int          n_concealed;
        int          n_resets;

        function new();
            en          = 1'b0;
            max_len     = MAX_LEN_RST;
            jump_lim    = JUMP_LIMIT_RST;
            startup_cnt = STARTUP_COUNT_RST;
            conceal_lim = CONCEAL_LIMIT_RST;
            bound       = 1'b0;
            bound_port  = '0;
            have_last   = 1'b0;
            last_seq    = '0;
            top_seq     = '0;
            play_pos    = '0;
            startup_left = '0;
            missing_run = '0;
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
                slot_seq[i]  = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENABLE:        en          = data[0];
                CFG_MAX_LEN:       max_len     = data[11:0];
                CFG_JUMP_LIMIT:    jump_lim    = data[7:0];
                CFG_STARTUP_COUNT: startup_cnt = data[2:0];
                CFG_CONCEAL_LIMIT: conceal_lim = data[2:0];
                default: ;
            endcase
        endfunction

        function bit is_before(seq_t a, seq_t b);
            return $signed(a - b) < 0;
        endfunction

        function int slot_of(seq_t s);
            int i;
            for (i = 0; i < TABLE_DEPTH; i++)
                if (slot_used[i] && slot_seq[i] == s)
                    return i;
            return -1;
        endfunction

        function out_t take_datagram(in_t it);
            out_t        r;
            logic [15:0] raw;
            seq_t        delta;
            seq_t        ext;
            int          slot;
            int          far;
            int          i;
            r = '0;
            if (!en || !it.addr_match || it.src_port == 16'd0)
                return r;
            if (it.length == PING_LEN && it.ping_match)
            begin
                if (!bound)
                begin
                    bound      = 1'b1;
                    bound_port = it.src_port;
                end
                r.accepted = (bound_port == it.src_port);
                return r;
            end
            if (!bound || bound_port != it.src_port || it.length <= MIN_HDR_LEN
                || it.length > max_len || it.hdr_byte0 != HDR0_VAL
                || it.hdr_byte1 != HDR1_VAL || it.magic_word != MAGIC_VAL)
                return r;
            raw   = have_last ? it.seq_number - last_seq : 16'd0;
            delta = {{48{raw[15]}}, raw};
            ext   = top_seq + delta;
            if (have_last && (is_before(ext, play_pos) || slot_of(ext) >= 0))
                return r;
            if (!it.payload_ok)
                return r;
            if (!have_last)
            begin
                play_pos     = ext;
                startup_left = startup_cnt;
            end
            else if (is_before(play_pos + 64'(jump_lim), ext))
            begin
                foreach (slot_used[k])
                    slot_used[k] = 1'b0;
                play_pos        = ext;
                startup_left    = startup_cnt;
                r.reset_decoder = 1'b1;
            end
            if (!have_last || (delta != '0 && !delta[63]))
            begin
                have_last = 1'b1;
                last_seq  = it.seq_number;
                top_seq   = ext;
            end
            slot = -1;
            for (i = 0; i < TABLE_DEPTH && slot < 0; i++)
                if (!slot_used[i])
                    slot = i;
            if (slot < 0)
            begin
                far = 0;
                for (i = 1; i < TABLE_DEPTH; i++)
                    if (is_before(slot_seq[far], slot_seq[i]))
                        far = i;
                if (is_before(slot_seq[far], ext))
                    return r;
                slot = far;
            end
            slot_used[slot] = 1'b1;
            slot_seq[slot]  = ext;
            r.accepted      = 1'b1;
            r.store_slot    = 2'(slot);
            r.store_valid   = 1'b1;
            return r;
        endfunction

        function out_t take_tick();
            out_t r;
            int   slot;
            bit   conceal;
            bit   any;
            r = '0;
            if (!en || !have_last)
                return r;
            if (startup_left != 3'd0)
            begin
                startup_left--;
                return r;
            end
            slot = slot_of(play_pos);
            if (slot < 0)
            begin
                conceal = missing_run < conceal_lim;
                if (missing_run != MISSING_MAX)
                    missing_run++;
                any = 1'b0;
                foreach (slot_used[k])
                    any |= slot_used[k];
                if (any)
                    play_pos++;
                if (conceal)
                    r.play_action = PLAY_CONCEAL;
                return r;
            end
            play_pos++;
            missing_run     = '0;
            slot_used[slot] = 1'b0;
            r.play_action   = PLAY_DECODE;
            r.play_slot     = 2'(slot);
            r.play_seq      = slot_seq[slot][15:0];
            return r;
        endfunction

        function void note_item(in_t it);
            out_t r;
            if (it.cmd == CMD_TICK)
                r = take_tick();
            else
                r = take_datagram(it);
            n_items++;
            if (r.store_valid)
                n_stored++;
            if (r.reset_decoder)
                n_resets++;
            if (r.play_action == PLAY_DECODE)
                n_decoded++;
            if (r.play_action == PLAY_CONCEAL)
                n_concealed++;
            expected_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare("accepted", 32'(want.accepted), 32'(got.accepted));
            compare("store_slot", 32'(want.store_slot), 32'(got.store_slot));
            compare("store_valid", 32'(want.store_valid), 32'(got.store_valid));
            compare("reset_decoder", 32'(want.reset_decoder), 32'(got.reset_decoder));
            compare("play_action", 32'(want.play_action), 32'(got.play_action));
            compare("play_slot", 32'(want.play_slot), 32'(got.play_slot));
            compare("play_seq", 32'(want.play_seq), 32'(got.play_seq));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    in_t                   item      = '0;
    logic                  done;
    out_t                  result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    jitter_tracker tracker = new();

    logic [15:0] peer;
    logic [15:0] head;
    int          burst_left = 0;
    int          n_settings = 0;

    always #1 clk = ~clk;

    audio_jitter_buffer_controller #(
        .QUEUE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(result);
    end

    function automatic in_t noise_item();
        return in_t'({$urandom, $urandom, $urandom});
    endfunction

    function automatic in_t tick_item();
        in_t it;
        it     = noise_item();
        it.cmd = CMD_TICK;
        return it;
    endfunction

    function automatic in_t ping_item(logic [15:0] port);
        in_t it;
        it            = noise_item();
        it.cmd        = CMD_DATAGRAM;
        it.addr_match = 1'b1;
        it.src_port   = port;
        it.length     = PING_LEN;
        it.ping_match = 1'b1;
        return it;
    endfunction

    function automatic in_t good_packet(logic [15:0] sq);
        in_t it;
        it            = noise_item();
        it.cmd        = CMD_DATAGRAM;
        it.addr_match = 1'b1;
        it.src_port   = peer;
        it.length     = 12'($urandom_range(13, int'(tracker.max_len)));
        if (it.length == PING_LEN)
            it.ping_match = 1'b0;
        it.hdr_byte0  = HDR0_VAL;
        it.hdr_byte1  = HDR1_VAL;
        it.seq_number = sq;
        it.magic_word = MAGIC_VAL;
        it.payload_ok = 1'b1;
        return it;
    endfunction

    function automatic in_t broken_packet(logic [15:0] sq);
        in_t it;
        it = good_packet(sq);
        case ($urandom_range(0, 8))
            0: it.addr_match = 1'b0;
            1: it.src_port   = 16'd0;
            2: it.src_port   = peer ^ 16'($urandom_range(1, 65535));
            3: it.length     = 12'($urandom_range(0, 12));
            4: it.length     = 12'($urandom_range(int'(tracker.max_len) + 1, 4095));
            5: it.hdr_byte0  = 8'($urandom_range(1, 255));
            6: it.hdr_byte1  = HDR1_VAL ^ 8'($urandom_range(1, 255));
            7: it.magic_word = MAGIC_VAL ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
            default: it.payload_ok = 1'b0;
        endcase
        return it;
    endfunction

    task automatic send(input in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            gap = $urandom_range(0, 9);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_item(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input bit en, input logic [11:0] max_len,
                             input logic [7:0] jump, input logic [2:0] startup,
                             input logic [2:0] conceal);
        logic [CFG_IDX_W-1:0]  idxs[5];
        logic [CFG_DATA_W-1:0] vals[5];
        int                    i;
        idxs = '{CFG_ENABLE, CFG_MAX_LEN, CFG_JUMP_LIMIT, CFG_STARTUP_COUNT,
                 CFG_CONCEAL_LIMIT};
        vals = '{12'(en), max_len, 12'(jump), 12'(startup), 12'(conceal)};
        drain();
        for (i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            tracker.write_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_stream(input int count);
        in_t it;
        int  pick;
        int  k;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                it = tick_item();
            else if (pick < 80)
            begin
                // advance the stream head and jitter around it
                head = head + 16'($urandom_range(0, 2));
                it = good_packet(head + 16'($urandom_range(0, 4)) - 16'd2);
            end
            else if (pick < 88)
            begin
                head = head + 16'($urandom_range(2, 600));
                it = good_packet(head);
            end
            else if (pick < 95)
                it = broken_packet(head + 16'($urandom_range(0, 3)));
            else if (pick < 98)
                it = ping_item($urandom_range(0, 1) ? peer : 16'($urandom));
            else
                it = noise_item();
            send(it);
        end
    endtask

    initial
    begin
        in_t it;
        int  p;
        peer = 16'($urandom_range(16'h0200, 16'hFFFF));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // block still disabled out of reset
        send(good_packet(16'h0010));
        send(tick_item());
        configure(1'b1, MAX_LEN_RST, JUMP_LIMIT_RST, STARTUP_COUNT_RST, CONCEAL_LIMIT_RST);

        send(good_packet(16'h0010));
        send(ping_item(16'd0));
        it = ping_item(peer);
        it.addr_match = 1'b0;
        send(it);
        send(ping_item(peer));
        send(ping_item(peer ^ 16'h0100));
        it = good_packet(16'hFFFE);
        it.length = MIN_HDR_LEN;
        send(it);
        it.length = MAX_LEN_RST + 12'd1;
        send(it);
        it.length = 12'hFFF;
        send(it);
        it = good_packet(16'hFFFE);
        it.hdr_byte0 = 8'hFF;
        send(it);
        it = good_packet(16'hFFFE);
        it.hdr_byte1 = 8'h00;
        send(it);
        it = good_packet(16'hFFFE);
        it.magic_word = ~MAGIC_VAL;
        send(it);
        it = good_packet(16'hFFFE);
        it.payload_ok = 1'b0;
        send(it);
        send(good_packet(16'hFFFE));
        send(good_packet(16'h0001));
        send(good_packet(16'hFFFE));
        repeat (5) send(tick_item());
        send(good_packet(16'hFFFD));
        send(good_packet(16'h0030));
        it = good_packet(16'h0031);
        it.length = MAX_LEN_RST;
        send(it);
        head = 16'h0031;

        for (p = 0; p < 7; p++)
        begin
            case (p)
                0: configure(1'b1, MAX_LEN_RST, JUMP_LIMIT_RST, STARTUP_COUNT_RST,
                             CONCEAL_LIMIT_RST);
                1: configure(1'b1, 12'd13, 8'd1, 3'd0, 3'd0);
                2: configure(1'b1, 12'd2048, 8'd255, 3'd7, 3'd7);
                3: configure(1'b0, 12'd2048, 8'd255, 3'd7, 3'd7);
                default: configure(1'b1, 12'($urandom_range(13, 2048)),
                                   8'($urandom_range(1, 255)), 3'($urandom),
                                   3'($urandom));
            endcase
            run_stream((p == 3) ? 40 : 215);
        end

        drain();
        repeat (2 * LATENCY) @(posedge clk);
        $display("covered %0d beats over %0d register settings", tracker.n_items, n_settings);
        $display("%0d stored, %0d decoded, %0d concealed, %0d decoder resets",
                 tracker.n_stored, tracker.n_decoded, tracker.n_concealed, tracker.n_resets);
        if (tracker.errors == 0 && tracker.expected_results.size() == 0)
            $display("audio_jitter_buffer_controller test passed");
        else
            $display("audio_jitter_buffer_controller test failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d results outstanding", tracker.expected_results.size());
        $display("audio_jitter_buffer_controller test failed");
        $finish;
    end

endmodule

// ----- audio_jitter_buffer_controller.f -----
+incdir+hw/rtl
hw/rtl/ajbc_pkg.sv
hw/rtl/ajbc_ctrl.sv
hw/rtl/ajbc_datapath.sv
hw/rtl/audio_jitter_buffer_controller.sv
hw/rtl/ajbc_checker.sv
tb/sv/audio_jitter_buffer_controller_tb.sv
